@@ hdl/bht_pkg.sv @@
// Shared types and constants for the bucketed hash table.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package bht_pkg;

  localparam int HASH_BITS  = 32;
  localparam int TAG_BITS   = 8;
  localparam int WORD_BITS  = 64;
  localparam int COUNT_BITS = 12;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_OVERWRITTEN = 3'd1,
    ST_FULL        = 3'd2,
    ST_FOUND       = 3'd3,
    ST_NOT_FOUND   = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PUT = 1'b0,
    KIND_GET = 1'b1
  } kind_t;

endpackage

`default_nettype wire

@@ hdl/bht_req_if.sv @@
// Request channel: valid/ready handshake carrying one put or get item.
// Depends on bht_pkg for field widths.
`default_nettype none

interface bht_req_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [bht_pkg::HASH_BITS-1:0]   key_hash;
  logic [bht_pkg::WORD_BITS-1:0]   key_word;
  logic [bht_pkg::WORD_BITS-1:0]   value_word;

  modport source (output valid, kind, key_hash, key_word, value_word, input ready);
  modport sink   (input valid, kind, key_hash, key_word, value_word, output ready);
endinterface

`default_nettype wire

@@ hdl/bht_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result item.
// Depends on bht_pkg for the status type and field widths.
`default_nettype none

interface bht_rsp_if;
  logic                             valid;
  logic                             ready;
  bht_pkg::status_t                 status;
  logic [bht_pkg::WORD_BITS-1:0]    read_value;
  logic [bht_pkg::COUNT_BITS-1:0]   entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

`default_nettype wire

@@ hdl/bucketed_hash_table_with_tags.sv @@
// Bucketed key/value hash table with per-entry tag byte (top level).
// Depends on bht_pkg, bht_req_if and bht_rsp_if.
//
// Usage:
//   req carries one item per handshake: kind (0 put, 1 get), key_hash,
//   key_word and value_word. rsp returns exactly one item per request with
//   status, read_value (the stored value on a found get, else zero) and
//   entry_count (occupied entries after the item, low 12 bits).
//   The top BUCKET_INDEX_BITS of key_hash pick a bucket, the low 8 bits are
//   the tag. Each bucket is one row of the table memory holding all ways.
// Lookup sequence:
//   An accepted item first has its bucket row read from the synchronous
//   RAM; in the lookup state that follows, all ways are compared, the row is
//   written back and the result is registered. No new item is taken until
//   the lookup is over.
// Reset:
//   rst clears control state and then starts a clearing pass that writes
//   every bucket row empty, one row per cycle, over all 2**BUCKET_INDEX_BITS
//   rows (256 at default), during which req.ready stays low.
// Stall:
//   The result sits in an output register. A new item is accepted only when
//   that register is empty or being drained in the same cycle, so a stalled
//   receiver holds the table idle with its result unchanged.
`default_nettype none

module bucketed_hash_table_with_tags #(
  parameter int BUCKET_INDEX_BITS = 8,
  parameter int WAYS_PER_BUCKET   = 8,
  parameter int KEY_BITS          = 64,
  parameter int VALUE_BITS        = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  bht_req_if.sink   req,
  bht_rsp_if.source rsp
);

  localparam int BUCKETS = 1 << BUCKET_INDEX_BITS;
  localparam int WAY_W   = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;

  // One way of a bucket row; occ lives in the RAM and is cleared by the sweep.
  typedef struct packed {
    logic                         occ;
    logic [bht_pkg::TAG_BITS-1:0] tag;
    logic [KEY_BITS-1:0]          key;
    logic [VALUE_BITS-1:0]        val;
  } way_t;

  typedef way_t [WAYS_PER_BUCKET-1:0] row_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t state;

  // Table memory: one row per bucket.
  row_t mem [BUCKETS];
  row_t row_q;

  logic [BUCKET_INDEX_BITS-1:0] clr_addr;

  // Latched item
  logic                         kind_q;
  logic [bht_pkg::TAG_BITS-1:0] tag_q;
  logic [KEY_BITS-1:0]          key_q;
  logic [VALUE_BITS-1:0]        val_q;
  logic [BUCKET_INDEX_BITS-1:0] bucket_q;

  logic [bht_pkg::COUNT_BITS-1:0] count;

  // Output register
  logic                             out_valid;
  bht_pkg::status_t                 out_status;
  logic [bht_pkg::WORD_BITS-1:0]    out_value;

  logic in_fire;
  logic [BUCKET_INDEX_BITS-1:0] in_bucket;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign in_fire   = req.valid && req.ready;
  assign in_bucket = req.key_hash[bht_pkg::HASH_BITS-1 -: BUCKET_INDEX_BITS];

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_value;
  assign rsp.entry_count = count;

  // Way compare: first matching way, first empty way.
  logic             hit;
  logic [WAY_W-1:0] hit_idx;
  logic             has_empty;
  logic [WAY_W-1:0] empty_idx;
  row_t             row_next;

  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    has_empty = 1'b0;
    empty_idx = '0;
    for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
      if (!hit && row_q[w].occ && (row_q[w].tag == tag_q) && (row_q[w].key == key_q)) begin
        hit     = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!has_empty && !row_q[w].occ) begin
        has_empty = 1'b1;
        empty_idx = WAY_W'(w);
      end
    end

    row_next = row_q;
    if (kind_q == bht_pkg::KIND_PUT) begin
      if (hit) begin
        row_next[hit_idx].val = val_q;
      end else if (has_empty) begin
        row_next[empty_idx].occ = 1'b1;
        row_next[empty_idx].tag = tag_q;
        row_next[empty_idx].key = key_q;
        row_next[empty_idx].val = val_q;
      end
    end
  end

  // Memory: sync read on accept, write-back in lookup, zero rows during sweep.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (state == S_LOOK) begin
      mem[bucket_q] <= row_next;
    end
    if (in_fire) begin
      row_q <= mem[in_bucket];
    end
  end

  // Control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BUCKET_INDEX_BITS'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          // read_value is the stored value only on a found get
          if ((kind_q == bht_pkg::KIND_GET) && hit) begin
            out_value <= bht_pkg::WORD_BITS'(row_q[hit_idx].val);
          end else begin
            out_value <= '0;
          end
          if (kind_q == bht_pkg::KIND_GET) begin
            if (hit) begin
              out_status <= bht_pkg::ST_FOUND;
            end else begin
              out_status <= bht_pkg::ST_NOT_FOUND;
            end
          end else if (hit) begin
            out_status <= bht_pkg::ST_OVERWRITTEN;
          end else if (has_empty) begin
            out_status <= bht_pkg::ST_INSERTED;
            count      <= count + 1'b1;
          end else begin
            out_status <= bht_pkg::ST_FULL;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q   <= req.kind;
      tag_q    <= req.key_hash[bht_pkg::TAG_BITS-1:0];
      key_q    <= req.key_word[KEY_BITS-1:0];
      val_q    <= req.value_word[VALUE_BITS-1:0];
      bucket_q <= in_bucket;
    end
  end

  // Every accepted item has its result registered after its lookup state.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> ##1 out_valid)
    else $error("result missing two cycles after accept");

  // Entry count moves only with a fresh insert result.
  a_count_insert: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (count != $past(count)) |->
      out_valid && (out_status == bht_pkg::ST_INSERTED) && $past(state == S_LOOK))
    else $error("entry count changed without insert");

  // No item is taken while a lookup is open.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_LOOK) && !in_fire)
    else $error("item accepted while busy");

endmodule

`default_nettype wire

@@ verif/table_checker.sv @@
`timescale 1ns / 1ps
// Checker for the bucketed hash table: watches both channels, keeps a shadow copy
// of the table and compares every result item against its prediction.
// Depends on bht_pkg, bht_req_if and bht_rsp_if.

module table_checker #(
  parameter int BUCKET_INDEX_BITS = 8,
  parameter int WAYS_PER_BUCKET   = 8,
  parameter int KEY_BITS          = 64,
  parameter int VALUE_BITS        = 64
) (
  input  logic clk,
  input  logic rst,
  bht_req_if   req,
  bht_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  import bht_pkg::*;

  localparam int SLOTS = (1 << BUCKET_INDEX_BITS) * WAYS_PER_BUCKET;
  localparam logic [WORD_BITS-1:0] KEY_MASK =
    (KEY_BITS >= WORD_BITS) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);
  localparam logic [WORD_BITS-1:0] VALUE_MASK =
    (VALUE_BITS >= WORD_BITS) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

  typedef struct {
    status_t               status;
    logic [WORD_BITS-1:0]  read_value;
    logic [COUNT_BITS-1:0] entry_count;
  } lookup_result_t;

  // shadow table
  bit                   slot_used  [SLOTS];
  logic [TAG_BITS-1:0]  slot_tag   [SLOTS];
  logic [WORD_BITS-1:0] slot_key   [SLOTS];
  logic [WORD_BITS-1:0] slot_value [SLOTS];
  int unsigned          used_slots;

  lookup_result_t owed_results [$];

  function automatic lookup_result_t apply_table_op(kind_t op, logic [HASH_BITS-1:0] hash,
                                                    logic [WORD_BITS-1:0] key_in,
                                                    logic [WORD_BITS-1:0] value_in);
    lookup_result_t       r;
    int                   base;
    int                   hit;
    int                   free_slot;
    logic [TAG_BITS-1:0]  tag;
    logic [WORD_BITS-1:0] key;
    tag       = hash[TAG_BITS-1:0];
    key       = key_in & KEY_MASK;
    base      = int'(hash[HASH_BITS-1 -: BUCKET_INDEX_BITS]) * WAYS_PER_BUCKET;
    hit       = -1;
    free_slot = -1;
    for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
      if (slot_used[base + w]) begin
        if (hit < 0 && slot_tag[base + w] == tag && slot_key[base + w] == key) hit = base + w;
      end else if (free_slot < 0) begin
        free_slot = base + w;
      end
    end
    r.read_value = '0;
    if (op == KIND_GET) begin
      if (hit >= 0) begin
        r.status     = ST_FOUND;
        r.read_value = slot_value[hit];
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else if (hit >= 0) begin
      slot_value[hit] = value_in & VALUE_MASK;
      r.status        = ST_OVERWRITTEN;
    end else if (free_slot >= 0) begin
      slot_used[free_slot]  = 1'b1;
      slot_tag[free_slot]   = tag;
      slot_key[free_slot]   = key;
      slot_value[free_slot] = value_in & VALUE_MASK;
      used_slots++;
      r.status = ST_INSERTED;
    end else begin
      r.status = ST_FULL;
    end
    r.entry_count = used_slots[COUNT_BITS-1:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Result side is handled before the request side so that a stray result
  // is never matched against an item accepted on the same edge.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      used_slots = 0;
      owed_results.delete();
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (owed_results.size() == 0) begin
          $error("result item with no request outstanding");
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
            fail_count++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
            fail_count++;
          end
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1)
        owed_results.push_back(apply_table_op(kind_t'(req.kind), req.key_hash,
                                              req.key_word, req.value_word));
    end
    pending = owed_results.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Top of the hash table testbench: clock, reset, put/get stimulus and verdict.
// Depends on bht_pkg, the channel interfaces, the block and table_checker.

module testbench;
  import bht_pkg::*;

  localparam int BUCKET_INDEX_BITS = 8;
  localparam int WAYS_PER_BUCKET   = 8;
  localparam int KEY_BITS          = 64;
  localparam int VALUE_BITS        = 64;

  localparam int ITEMS_PER_PHASE = 275;
  localparam int KEY_POOL        = 40;   // recurring keys, spread over few buckets
  localparam int HOT_BUCKETS     = 4;
  localparam int NOISE_PCT       = 15;   // share of fully random items
  // Cycles with no handshake at all before giving up; covers the clearing
  // pass after reset (256 rows) plus the longest plausible random stall.
  localparam int WATCHDOG_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst;

  int send_idle_pct;   // chance per cycle that the sender holds off
  int stall_pct;       // chance per cycle that the receiver stalls
  int fail_count;
  int pending;
  int idle_cycles;

  bht_req_if req_ch ();
  bht_rsp_if rsp_ch ();

  bucketed_hash_table_with_tags #(
    .BUCKET_INDEX_BITS (BUCKET_INDEX_BITS),
    .WAYS_PER_BUCKET   (WAYS_PER_BUCKET),
    .KEY_BITS          (KEY_BITS),
    .VALUE_BITS        (VALUE_BITS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  table_checker #(
    .BUCKET_INDEX_BITS (BUCKET_INDEX_BITS),
    .WAYS_PER_BUCKET   (WAYS_PER_BUCKET),
    .KEY_BITS          (KEY_BITS),
    .VALUE_BITS        (VALUE_BITS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Receiver: ready is redrawn every falling edge; with stall_pct at zero it
  // stays high, which gives the stretches with no back-pressure.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: any handshake on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one item and hold it until it is taken. Called and returning at a
  // falling edge. valid is dropped only when a gap is drawn, so it never gets
  // two assignments in one time step.
  task automatic send_item(input kind_t op, input logic [HASH_BITS-1:0] hash,
                           input logic [WORD_BITS-1:0] key, input logic [WORD_BITS-1:0] value);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= op;
    req_ch.key_hash   <= hash;
    req_ch.key_word   <= key;
    req_ch.value_word <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Recurring keys: each phase draws a few hot buckets and a pool of keys in
  // them. Some pool entries share a tag but not the key, others share the key
  // but not the tag, so the tag and the key compare are both exercised. Forty
  // keys over 32 ways make full buckets common once the pool warms up.
  logic [BUCKET_INDEX_BITS-1:0] hot_bucket  [HOT_BUCKETS];
  logic [BUCKET_INDEX_BITS-1:0] pool_bucket [KEY_POOL];
  logic [TAG_BITS-1:0]          pool_tag    [KEY_POOL];
  logic [WORD_BITS-1:0]         pool_key    [KEY_POOL];

  initial begin
    logic [HASH_BITS-1:0] hash;
    int                   pick;
    int                   shape;

    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_PUT;
    req_ch.key_hash   = '0;
    req_ch.key_word   = '0;
    req_ch.value_word = '0;
    rsp_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    stall_pct         = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // gets on an empty table, at both extremes of hash and key
    send_item(KIND_GET, 32'h0000_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_GET, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    // insert at the top bucket/tag, read back, overwrite, read back
    send_item(KIND_PUT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_GET, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_item(KIND_PUT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_item(KIND_GET, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0);
    // bucket 0: same key with two tags, and a second key under tag 0
    send_item(KIND_PUT, 32'h0000_0000, 64'h0, 64'h5555_5555_5555_5555);
    send_item(KIND_PUT, 32'h0000_00FF, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(KIND_PUT, 32'h0000_0000, 64'h8000_0000_0000_0001, 64'h0F0F_0F0F_0F0F_0F0F);
    // fill the remaining ways of bucket 0, then one more put finds it full
    for (int w = 0; w < WAYS_PER_BUCKET - 3; w++)
      send_item(KIND_PUT, {8'h00, 16'(w * 4099), 8'(w + 1)}, 64'(w + 100), 64'(~w));
    send_item(KIND_PUT, 32'h0000_0042, 64'hDEAD_BEEF_0000_0042, 64'h1);
    send_item(KIND_GET, 32'h0000_0042, 64'hDEAD_BEEF_0000_0042, 64'h0);
    // hits whose middle hash bits differ from the stored item's
    send_item(KIND_GET, 32'h00AB_CD00, 64'h0, 64'h0);
    send_item(KIND_GET, 32'h0012_34FF, 64'h0, 64'h0);

    // ---- random, one phase per idling mode ----
    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase

      for (int b = 0; b < HOT_BUCKETS; b++) hot_bucket[b] = BUCKET_INDEX_BITS'($urandom);
      for (int i = 0; i < KEY_POOL; i++) begin
        shape = (i == 0) ? 5 : $urandom_range(0, 5);
        if (shape == 0) begin          // tag twin: same bucket and tag, new key
          pool_bucket[i] = pool_bucket[i-1];
          pool_tag[i]    = pool_tag[i-1];
          pool_key[i]    = {$urandom, $urandom};
        end else if (shape == 1) begin // key twin: same bucket and key, new tag
          pool_bucket[i] = pool_bucket[i-1];
          pool_tag[i]    = pool_tag[i-1] ^ 8'($urandom_range(1, 255));
          pool_key[i]    = pool_key[i-1];
        end else begin
          pool_bucket[i] = hot_bucket[$urandom_range(0, HOT_BUCKETS - 1)];
          pool_tag[i]    = 8'($urandom);
          pool_key[i]    = {$urandom, $urandom};
        end
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < NOISE_PCT) begin
          // noise: any bucket, tag and key, almost always a miss or a fresh insert
          send_item(kind_t'($urandom_range(0, 1)), $urandom, {$urandom, $urandom},
                    {$urandom, $urandom});
        end else begin
          // pool key; the middle hash bits are redrawn since only bucket and tag count
          pick = $urandom_range(0, KEY_POOL - 1);
          hash = $urandom;
          hash[HASH_BITS-1 -: BUCKET_INDEX_BITS] = pool_bucket[pick];
          hash[TAG_BITS-1:0] = pool_tag[pick];
          send_item(kind_t'($urandom_range(0, 1)), hash, pool_key[pick], {$urandom, $urandom});
        end
      end
    end

    req_ch.valid <= 1'b0;

    // drain, then a few more cycles so a stray late result would still be caught
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/bht_pkg.sv
hdl/bht_req_if.sv
hdl/bht_rsp_if.sv
hdl/bucketed_hash_table_with_tags.sv
verif/table_checker.sv
verif/testbench.sv
